/* rtl/core/rsa_pkg.sv */
package rsa_pkg;

  localparam int WORD_W = 64;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NOINV  = 2'd1;
  localparam logic [1:0] STATUS_PRIME  = 2'd2;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,     // latch primes, p-1, q-1, gcd operands
    CMD_MUL_N,    // n = p*q (partial product step)
    CMD_DIV_START,// start division num/den
    CMD_GCD_STEP, // a<=b, b<=rem
    CMD_LAM_DIV,  // start (pm1/g)
    CMD_LAM_MUL,  // lam = quot*qm1 (partial product step)
    CMD_INV_INIT, // r0=e, r1=lam, s0=1, s1=0
    CMD_INV_DIV,  // start r0/r1
    CMD_INV_MUL,  // qt*s1 partial product step
    CMD_INV_STEP, // rotate
    CMD_RED_DIV,  // start s0 % lam
    CMD_FINISH,   // form d
    CMD_MUL_LOAD  // latch quotient and second operand for a product
  } cmd_t;

  typedef struct packed {
    logic prime_bad;
    logic b_zero;
    logic r1_zero;
    logic r0_one;
    logic div_done;
  } stat_t;

endpackage

/* rtl/core/rsa_div.sv */
module rsa_div import rsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] num,
  input  logic [WORD_W-1:0] den,
  output logic              done,
  output logic [WORD_W-1:0] quot,
  output logic [WORD_W-1:0] rem
);
  logic [WORD_W-1:0] q_r, q_nxt, r_r, r_nxt, d_r;
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [WORD_W:0] sh, diff;

  assign sh   = {r_r, q_r[WORD_W-1]};
  assign diff = sh - {1'b0, d_r};

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    if (start) begin
      q_nxt = num; r_nxt = '0; cnt_nxt = 7'd0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[WORD_W]) begin
        r_nxt = diff[WORD_W-1:0];
        q_nxt = {q_r[WORD_W-2:0], 1'b1};
      end else begin
        r_nxt = sh[WORD_W-1:0];
        q_nxt = {q_r[WORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'(WORD_W - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (start) d_r <= den;
  end

  assign done = !busy_r && !start;
  assign quot = q_r;
  assign rem  = r_r;
endmodule

/* rtl/core/rsa_datapath.sv */
module rsa_datapath import rsa_pkg::*; #(
  parameter int PRIME_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [31:0]       prime_p,
  input  logic [31:0]       prime_q,
  input  logic [31:0]       exp_e,
  output stat_t             stat,
  output logic [WORD_W-1:0] n_o,
  output logic [WORD_W-1:0] lam_o,
  output logic [WORD_W-1:0] d_o
);
  logic [WORD_W-1:0] n_r, pm1_r, qm1_r, a_r, b_r, lam_r, d_r;
  logic [WORD_W-1:0] r0_r, r1_r, s0_r, s1_r, qt_r;
  logic [WORD_W-1:0] mop_r, mac_r;
  logic [WORD_W-1:0] mmul_r;
  logic [2:0] mcnt_r;
  logic neg0_r, pbad_r;
  logic lam_phase_r;
  logic [WORD_W-1:0] p_m, q_m;
  logic div_start;
  logic [WORD_W-1:0] div_num, div_den, quot, rem;
  logic div_done;
  logic [WORD_W-1:0] pprod;
  logic [WORD_W-1:0] red;

  assign p_m = WORD_W'(prime_p[PRIME_BITS-1:0]);
  assign q_m = WORD_W'(prime_q[PRIME_BITS-1:0]);

  // 8-bit digit of multiplier times 64-bit operand, eight steps
  assign pprod = mop_r * WORD_W'(mmul_r[7:0]);

  always_comb begin
    div_start = 1'b0; div_num = a_r; div_den = b_r;
    case (cmd)
      CMD_DIV_START: begin div_start = 1'b1; div_num = a_r;  div_den = b_r;  end
      CMD_LAM_DIV:   begin div_start = 1'b1; div_num = pm1_r; div_den = a_r; end
      CMD_INV_DIV:   begin div_start = 1'b1; div_num = r0_r; div_den = r1_r; end
      CMD_RED_DIV:   begin div_start = 1'b1; div_num = s0_r; div_den = lam_r; end
      default: ;
    endcase
  end

  rsa_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(quot), .rem(rem)
  );

  assign red = (neg0_r && rem != '0) ? lam_r - rem : rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= '0;
    end else begin
      case (cmd)
        CMD_LOAD, CMD_LAM_DIV, CMD_INV_DIV, CMD_MUL_LOAD: mcnt_r <= '0;
        CMD_MUL_N, CMD_LAM_MUL, CMD_INV_MUL: mcnt_r <= mcnt_r + 3'd1;
        default: ;
      endcase
    end
    case (cmd)
      CMD_LOAD: begin
        pbad_r <= (p_m < 64'd2) || (q_m < 64'd2);
        pm1_r  <= p_m - 64'd1; qm1_r <= q_m - 64'd1;
        a_r    <= p_m - 64'd1; b_r   <= q_m - 64'd1;
        mop_r  <= p_m; mmul_r <= q_m; mac_r <= '0;
      end
      CMD_MUL_LOAD: begin
        mop_r  <= quot;
        mmul_r <= lam_phase_r ? qm1_r : s1_r;
        mac_r  <= '0;
      end
      CMD_MUL_N, CMD_LAM_MUL, CMD_INV_MUL: begin
        mac_r  <= mac_r + pprod;
        mop_r  <= mop_r << 8;
        mmul_r <= mmul_r >> 8;
        if (cmd == CMD_MUL_N && mcnt_r == 3'd7) n_r <= mac_r + pprod;
        if (cmd == CMD_LAM_MUL && mcnt_r == 3'd7) lam_r <= mac_r + pprod;
      end
      CMD_GCD_STEP: begin a_r <= b_r; b_r <= rem; end
      CMD_INV_INIT: begin
        r0_r <= WORD_W'(exp_e); r1_r <= lam_r;
        s0_r <= 64'd1; s1_r <= '0; neg0_r <= 1'b0;
      end
      CMD_INV_STEP: begin
        r0_r <= r1_r; r1_r <= rem;
        s0_r <= s1_r; s1_r <= s0_r + mac_r;
        neg0_r <= !neg0_r;
      end
      CMD_FINISH: d_r <= red;
      default: ;
    endcase
  end

  // operand routing for the quotient products
  always_ff @(posedge clk) begin
    if (!rst_n) lam_phase_r <= 1'b0;
    else if (cmd == CMD_LAM_DIV) lam_phase_r <= 1'b1;
    else if (cmd == CMD_INV_INIT) lam_phase_r <= 1'b0;
  end

  assign stat.prime_bad = pbad_r;
  assign stat.b_zero    = (b_r == '0);
  assign stat.r1_zero   = (r1_r == '0);
  assign stat.r0_one    = (r0_r == 64'd1);
  assign stat.div_done  = div_done;
  assign n_o   = n_r;
  assign lam_o = lam_r;
  assign d_o   = d_r;
endmodule

/* rtl/core/rsa_ctrl.sv */
module rsa_ctrl import rsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       out_take,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       idle,
  output logic       res_valid,
  output logic [1:0] res_status
);
  localparam logic [3:0] S_IDLE = 4'd0, S_MULN = 4'd1, S_GCD = 4'd2, S_GCDW = 4'd3,
    S_LDIVW = 4'd5, S_LMUL = 4'd6, S_IINIT = 4'd7, S_ICHK = 4'd8,
    S_IDIVW = 4'd9, S_IMUL = 4'd10, S_RDIVW = 4'd11, S_FIN = 4'd12, S_OUT = 4'd13,
    S_LOAD = 4'd14, S_IWAIT = 4'd15;

  logic [3:0] st_r, st_nxt;
  logic [1:0] status_r, status_nxt;
  logic mul_last;
  logic [2:0] mc_r;
  logic is_mul;

  assign is_mul = (cmd == CMD_MUL_N) || (cmd == CMD_LAM_MUL) || (cmd == CMD_INV_MUL);

  always_comb begin
    st_nxt = st_r; status_nxt = status_r; cmd = CMD_NONE;
    case (st_r)
      S_IDLE:  if (start) begin cmd = CMD_LOAD; st_nxt = S_LOAD; end
      S_LOAD:  if (stat.prime_bad) begin
                 status_nxt = STATUS_PRIME; st_nxt = S_OUT;
               end else st_nxt = S_MULN;
      S_MULN: begin cmd = CMD_MUL_N; st_nxt = S_MULN; end
      S_GCD:   if (stat.b_zero) begin cmd = CMD_LAM_DIV; st_nxt = S_LDIVW; end
               else begin cmd = CMD_DIV_START; st_nxt = S_GCDW; end
      S_GCDW:  if (stat.div_done) begin cmd = CMD_GCD_STEP; st_nxt = S_GCD; end
      S_LDIVW: if (stat.div_done) begin cmd = CMD_MUL_LOAD; st_nxt = S_LMUL; end
      S_LMUL: begin cmd = CMD_LAM_MUL; st_nxt = S_LMUL; end
      S_IINIT: begin cmd = CMD_INV_INIT; st_nxt = S_ICHK; end
      S_ICHK:  if (stat.r1_zero) begin
                 if (stat.r0_one) begin cmd = CMD_RED_DIV; st_nxt = S_RDIVW; end
                 else begin status_nxt = STATUS_NOINV; st_nxt = S_OUT; end
               end else begin cmd = CMD_INV_DIV; st_nxt = S_IDIVW; end
      S_IDIVW: if (stat.div_done) begin cmd = CMD_MUL_LOAD; st_nxt = S_IMUL; end
      S_IMUL: begin cmd = CMD_INV_MUL; st_nxt = S_IMUL; end
      S_IWAIT: begin cmd = CMD_INV_STEP; st_nxt = S_ICHK; end
      S_RDIVW: if (stat.div_done) st_nxt = S_FIN;
      S_FIN:   begin cmd = CMD_FINISH; status_nxt = STATUS_OK; st_nxt = S_OUT; end
      S_OUT:   if (out_take) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    // eight-step multiplies end when the count wraps
    if (cmd == CMD_MUL_N || cmd == CMD_LAM_MUL || cmd == CMD_INV_MUL) begin
      if (mul_last) begin
        case (st_r)
          S_MULN:  st_nxt = S_GCD;
          S_LMUL:  st_nxt = S_IINIT;
          default: st_nxt = S_IWAIT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mc_r <= '0;
    else if (is_mul) mc_r <= mc_r + 3'd1;
    else mc_r <= '0;
  end
  assign mul_last = (mc_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      status_r <= STATUS_OK;
    end else begin
      st_r <= st_nxt;
      status_r <= status_nxt;
    end
  end

  assign idle = (st_r == S_IDLE);
  assign res_valid = (st_r == S_OUT);
  assign res_status = status_r;
endmodule

/* rtl/core/rsa_private_exponent_top.sv */
// One item at a time, with all divisions on the shared restoring divider;
// in_tready returns the cycle after the result beat.
// A prime below two sends the controller from its load state straight to the
// result state, skipping the computation.
// Reset (rst_n low, synchronous): controller idle, no result pending,
// public exponent back to 65537.
module rsa_private_exponent_top import rsa_pkg::*; #(
  parameter int PRIME_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // prime_p, prime_q
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata   // modulus, carmichael_lambda, private_exponent, status, pad
);
  logic [31:0] e_r;
  cmd_t cmd;
  stat_t stat;
  logic idle, res_valid;
  logic [1:0] res_status;
  logic [WORD_W-1:0] n_w, lam_w, d_w;

  always_ff @(posedge clk) begin
    if (!rst_n) e_r <= 32'd65537;
    else if (cfg_we) e_r <= cfg_wdata;
  end

  assign in_tready = idle;

  rsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(in_tvalid && idle), .out_take(out_tready),
    .stat(stat), .cmd(cmd), .idle(idle), .res_valid(res_valid), .res_status(res_status)
  );

  rsa_datapath #(.PRIME_BITS(PRIME_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .prime_p(in_tdata[31:0]),
    .prime_q(in_tdata[63:32]), .exp_e(e_r), .stat(stat), .n_o(n_w), .lam_o(lam_w), .d_o(d_w)
  );

  logic ok;
  assign ok = (res_status == STATUS_OK);
  assign out_tvalid = res_valid;
  assign out_tdata = {6'd0, res_status, ok ? d_w : 64'd0, ok ? lam_w : 64'd0,
                      ok ? n_w : 64'd0};
endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import rsa_pkg::*;

  localparam int  LIMIT_CYCLES = 6_000_000;
  localparam int  DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [63:0] modulus;
    logic [63:0] lambda;
    logic [63:0] priv_exp;
    logic [1:0]  status;
  } key_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [31:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;   // prime_p, prime_q
  logic         out_tvalid;
  logic         out_tready;
  logic [199:0] out_tdata;  // modulus, carmichael_lambda, private_exponent, status, pad

  rsa_private_exponent_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  key_t        pending_keys[$];
  logic [31:0] exponent;
  int          errors;
  int          cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_off;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic key_t derive_key(logic [31:0] p, logic [31:0] q, logic [31:0] e);
    key_t        k;
    logic [63:0] pm1, qm1, lam, r0, r1, r2, s0, s1, s2, qt, red;
    logic        neg0;
    k = '0;
    if (p < 2 || q < 2) begin
      k.status = STATUS_PRIME;
      return k;
    end
    pm1 = {32'd0, p} - 1;
    qm1 = {32'd0, q} - 1;
    lam = (pm1 / gcd64(pm1, qm1)) * qm1;
    r0 = {32'd0, e};
    r1 = lam;
    s0 = 1;
    s1 = 0;
    neg0 = 1'b0;
    while (r1 != 0) begin
      qt = r0 / r1;
      r2 = r0 - qt * r1;
      s2 = s0 + qt * s1;
      r0 = r1;
      r1 = r2;
      s0 = s1;
      s1 = s2;
      neg0 = ~neg0;
    end
    if (r0 != 1) begin
      k.status = STATUS_NOINV;
      return k;
    end
    red = s0 % lam;
    if (neg0 && red != 0) red = lam - red;
    k.modulus  = {32'd0, p} * {32'd0, q};
    k.lambda   = lam;
    k.priv_exp = red;
    k.status   = STATUS_OK;
    return k;
  endfunction

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off   <= hold_off - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    key_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.modulus  = out_tdata[63:0];
      got.lambda   = out_tdata[127:64];
      got.priv_exp = out_tdata[191:128];
      got.status   = out_tdata[193:192];
      if (pending_keys.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
      end else begin
        want = pending_keys.pop_front();
        if (got.modulus != want.modulus) begin
          $display("%0t: modulus exp %h got %h", $realtime, want.modulus, got.modulus);
          errors++;
        end
        if (got.lambda != want.lambda) begin
          $display("%0t: lambda exp %h got %h", $realtime, want.lambda, got.lambda);
          errors++;
        end
        if (got.priv_exp != want.priv_exp) begin
          $display("%0t: d exp %h got %h", $realtime, want.priv_exp, got.priv_exp);
          errors++;
        end
        if (got.status != want.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
          errors++;
        end
      end
    end
  end

  task automatic send_primes(logic [31:0] p, logic [31:0] q);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata  = {$urandom, $urandom};
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {q, p};
    do @(posedge clk); while (!in_tready);
    pending_keys.push_back(derive_key(p, q, exponent));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_exponent(logic [31:0] e);
    wait_drained();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = e;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = $urandom;
    exponent  = e;
  endtask

  function automatic logic [31:0] pick_prime();
    case ($urandom_range(9))
      0:       return $urandom_range(3);
      1, 2, 3: return $urandom_range(1000, 2);
      4:       return $urandom | 32'h8000_0001;
      default: return $urandom | 32'h1;
    endcase
  endfunction

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_primes(32'd0, 32'd0);
    send_primes(32'd1, 32'd5);
    send_primes(32'd5, 32'd1);
    send_primes(32'd61, 32'd53);
    send_primes(32'd2, 32'd2);
    send_primes(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_primes(32'hFFFF_FFFB, 32'hFFFF_FFEF);
    send_primes(32'hFFFF_FFFB, 32'd3);
    send_primes(32'd65539, 32'd65537);
    set_exponent(32'd3);
    send_primes(32'd7, 32'd11);
    send_primes(32'd5, 32'd11);
    send_primes(32'd2, 32'd2);
    set_exponent(32'd0);
    send_primes(32'd2, 32'd2);
    send_primes(32'd3, 32'd5);
    set_exponent(32'd1);
    send_primes(32'd13, 32'd17);
    send_primes(32'hFFFF_FFFB, 32'hFFFF_FFEF);
    set_exponent(32'hFFFF_FFFF);
    send_primes(32'd3, 32'd3);
    send_primes(32'hFFFF_FFFB, 32'hFFFF_FFEF);
    send_primes(32'd103, 32'd2);
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_primes(pick_prime(), pick_prime());
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_off = 20000;
    repeat (4) send_primes(pick_prime(), pick_prime());
  endtask

  initial begin
    errors = 0; cycles = 0; hold_off = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    exponent = 32'd65537;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_exponent(32'd65537);
    test_directed();
    set_exponent(32'd65537);
    test_random(20, 0, 0);
    set_exponent(32'd3);
    test_random(20, 77, 0);
    set_exponent($urandom | 32'h1);
    test_random(20, 0, 77);
    set_exponent(32'd17);
    test_random(20, 15, 15);
    test_backpressure();
    wait_drained();

    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

/* rsa_private_exponent_top.f */
rtl/core/rsa_pkg.sv
rtl/core/rsa_div.sv
rtl/core/rsa_datapath.sv
rtl/core/rsa_ctrl.sv
rtl/core/rsa_private_exponent_top.sv
tb/sv/tb_top.sv
